[rtl/core/drke_pkg.sv]
// ----------------------------------------------------------------------------
// drke_pkg
// Shared types and constants for the DER RSA key extractor.
// ----------------------------------------------------------------------------
package drke_pkg;

  // Default upper limit on the stripped modulus length, in bytes
  localparam int unsigned ModBytesDefault = 512;

  // Result queue depth and pointer width
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;

  // Field widths of one result beat
  localparam int unsigned ModLenW = 10;
  localparam int unsigned ExpW    = 32;

  // DER tags and header codes
  localparam logic [7:0] TagSequence  = 8'h30;
  localparam logic [7:0] TagVersion   = 8'hA0;
  localparam logic [7:0] TagBitString = 8'h03;
  localparam logic [7:0] TagInteger   = 8'h02;
  localparam logic [7:0] PadByte      = 8'h00;
  localparam logic [7:0] ZeroByte     = 8'h00;
  localparam logic [6:0] LongLenMask  = 7'h7F;
  localparam logic [2:0] MaxLenBytes  = 3'd4;

  // Result kinds
  localparam logic KindModByte = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // Status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         modulus_byte;
    logic               status;
    logic [ModLenW-1:0] modulus_length;
    logic [ExpW-1:0]    exponent;
  } res_t;

  // Results raised by one accepted input beat: a modulus byte, the final
  // status, or both (modulus byte first).
  typedef struct packed {
    logic mod_vld;
    logic stat_vld;
    res_t mod_res;
    res_t stat_res;
  } push_t;

endpackage

[rtl/core/drke_parser.sv]
// ----------------------------------------------------------------------------
// drke_parser
// Byte-wide DER walker: TLV headers, bound checks, modulus and exponent.
// ----------------------------------------------------------------------------
module drke_parser #(
  parameter int unsigned ModBytes = drke_pkg::ModBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      cert_byte_i,
  input  logic            buffer_end_i,
  output drke_pkg::push_t push_o
);
  import drke_pkg::*;

  localparam int unsigned CntW = $clog2(ModBytes + 1);

  // length byte tracker codes
  localparam logic [2:0] LblTag   = 3'd0;
  localparam logic [2:0] LblFirst = 3'd5;

  typedef enum logic [4:0] {
    PhCert       = 5'd0,
    PhTbs        = 5'd1,
    PhFirst      = 5'd2,
    PhVerSkip    = 5'd3,
    PhSerial     = 5'd4,
    PhSerialSkip = 5'd5,
    PhAlg        = 5'd6,
    PhAlgSkip    = 5'd7,
    PhIssuer     = 5'd8,
    PhIssuerSkip = 5'd9,
    PhValid      = 5'd10,
    PhValidSkip  = 5'd11,
    PhSubj       = 5'd12,
    PhSubjSkip   = 5'd13,
    PhKeyInfo    = 5'd14,
    PhAlg2       = 5'd15,
    PhAlg2Skip   = 5'd16,
    PhBits       = 5'd17,
    PhPad        = 5'd18,
    PhKeySeq     = 5'd19,
    PhMod        = 5'd20,
    PhModFirst   = 5'd21,
    PhModBody    = 5'd22,
    PhExp        = 5'd23,
    PhExpBody    = 5'd24,
    PhDone       = 5'd25
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              ver_q, ver_d;
  logic [31:0]       acc_q, acc_d;
  logic [2:0]        lbl_q, lbl_d;
  logic [31:0]       outer_q, outer_d;
  logic [31:0]       tbs_q, tbs_d;
  logic [31:0]       keyinfo_q, keyinfo_d;
  logic [31:0]       bits_q, bits_d;
  logic [31:0]       keyseq_q, keyseq_d;
  logic [31:0]       elem_q, elem_d;
  logic [31:0]       exp_q, exp_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              err_q, err_d;

  logic              active;
  logic              is_hdr;
  logic              bounded;
  logic [31:0]       enc;
  logic              any_tag;
  logic [7:0]        want_tag;
  logic              hdr_done;
  logic [31:0]       hdr_len;
  phase_e            skip_base;
  logic              emit_mod;
  logic              stat_bad;

  function automatic logic [31:0] dec32(input logic [31:0] v);
    return (v != '0) ? v - 32'd1 : '0;
  endfunction

  // Enclosing room and expected tag of the header being parsed
  always_comb begin
    is_hdr   = 1'b1;
    bounded  = 1'b1;
    enc      = tbs_q;
    any_tag  = 1'b1;
    want_tag = TagSequence;
    case (phase_q)
      PhCert: begin
        bounded = 1'b0;
        enc     = '0;
        any_tag = 1'b0;
      end
      PhTbs: begin
        enc     = outer_q;
        any_tag = 1'b0;
      end
      PhKeyInfo: begin
        any_tag = 1'b0;
      end
      PhFirst, PhSerial, PhAlg, PhIssuer, PhValid, PhSubj: begin
        enc = tbs_q;
      end
      PhAlg2: begin
        enc = keyinfo_q;
      end
      PhBits: begin
        enc      = keyinfo_q;
        any_tag  = 1'b0;
        want_tag = TagBitString;
      end
      PhKeySeq: begin
        enc     = bits_q;
        any_tag = 1'b0;
      end
      PhMod, PhExp: begin
        enc      = keyseq_q;
        any_tag  = 1'b0;
        want_tag = TagInteger;
      end
      default: begin
        is_hdr = 1'b0;
      end
    endcase
  end

  assign active    = !err_q && (phase_q != PhDone);
  assign hdr_len   = (lbl_q == LblFirst) ? {24'h0, cert_byte_i} : {acc_q[23:0], cert_byte_i};
  assign skip_base = ver_q ? PhFirst : PhSerial;

  always_comb begin
    phase_d   = phase_q;
    ver_d     = ver_q;
    acc_d     = acc_q;
    lbl_d     = lbl_q;
    outer_d   = outer_q;
    tbs_d     = tbs_q;
    keyinfo_d = keyinfo_q;
    bits_d    = bits_q;
    keyseq_d  = keyseq_q;
    elem_d    = elem_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    hdr_done  = 1'b0;
    emit_mod  = 1'b0;
    stat_bad  = 1'b0;

    push_o                         = '0;
    push_o.mod_res.kind            = KindModByte;
    push_o.mod_res.modulus_byte    = cert_byte_i;
    push_o.mod_res.status          = StatusOk;
    push_o.stat_res.kind           = KindStatus;

    if (accept_i) begin
      outer_d   = dec32(outer_q);
      tbs_d     = dec32(tbs_q);
      keyinfo_d = dec32(keyinfo_q);
      bits_d    = dec32(bits_q);
      keyseq_d  = dec32(keyseq_q);
      elem_d    = dec32(elem_q);

      if (active) begin
        if (is_hdr) begin
          if (bounded && (enc == '0)) begin
            err_d = 1'b1;
          end else if (lbl_q == LblTag) begin
            ver_d = (cert_byte_i == TagVersion);
            if (!any_tag && (cert_byte_i != want_tag)) begin
              err_d = 1'b1;
            end else begin
              lbl_d = LblFirst;
            end
          end else if (lbl_q == LblFirst) begin
            if (cert_byte_i[7]) begin
              if (((cert_byte_i[6:0] & LongLenMask) == '0) ||
                  (cert_byte_i[6:0] > 7'(MaxLenBytes))) begin
                err_d = 1'b1;
              end else begin
                acc_d = '0;
                lbl_d = cert_byte_i[2:0];
              end
            end else begin
              acc_d    = hdr_len;
              hdr_done = 1'b1;
            end
          end else begin
            acc_d = hdr_len;
            lbl_d = lbl_q - 3'd1;
            if (lbl_q == 3'd1) begin
              hdr_done = 1'b1;
            end
          end
        end else begin
          case (phase_q)
            PhPad: begin
              if (cert_byte_i != PadByte) begin
                err_d = 1'b1;
              end else begin
                phase_d = PhKeySeq;
              end
            end
            PhModFirst: begin
              if ((elem_q > 32'd1) && (cert_byte_i == ZeroByte)) begin
                phase_d = (elem_d != '0) ? PhModBody : PhExp;
              end else if (elem_q > 32'(ModBytes)) begin
                err_d = 1'b1;
              end else begin
                emit_mod = 1'b1;
                phase_d  = (elem_d != '0) ? PhModBody : PhExp;
              end
            end
            PhModBody: begin
              emit_mod = 1'b1;
              if (elem_d == '0) begin
                phase_d = PhExp;
              end
            end
            PhExpBody: begin
              exp_d = {exp_q[23:0], cert_byte_i};
              if (elem_d == '0) begin
                phase_d = PhDone;
              end
            end
            PhVerSkip, PhSerialSkip, PhAlgSkip, PhIssuerSkip, PhValidSkip,
            PhSubjSkip, PhAlg2Skip: begin
              if (elem_d == '0) begin
                phase_d = phase_e'(phase_q + 5'd1);
              end
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
      end

      // header complete: check fit, then open the element
      if (hdr_done) begin
        lbl_d = LblTag;
        if (bounded && (hdr_len >= enc)) begin
          err_d = 1'b1;
        end else begin
          case (phase_q)
            PhCert: begin
              outer_d = hdr_len;
              phase_d = PhTbs;
            end
            PhTbs: begin
              tbs_d   = hdr_len;
              phase_d = PhFirst;
            end
            PhFirst: begin
              elem_d  = hdr_len;
              phase_d = (hdr_len != '0) ? phase_e'(skip_base + 5'd1)
                                        : phase_e'(skip_base + 5'd2);
            end
            PhKeyInfo: begin
              keyinfo_d = hdr_len;
              phase_d   = PhAlg2;
            end
            PhBits: begin
              bits_d = hdr_len;
              if (hdr_len == '0) begin
                err_d = 1'b1;
              end else begin
                phase_d = PhPad;
              end
            end
            PhKeySeq: begin
              keyseq_d = hdr_len;
              phase_d  = PhMod;
            end
            PhMod: begin
              if (hdr_len > 32'(ModBytes + 1)) begin
                err_d = 1'b1;
              end else begin
                elem_d  = hdr_len;
                phase_d = (hdr_len != '0) ? PhModFirst : PhExp;
              end
            end
            PhExp: begin
              elem_d  = hdr_len;
              exp_d   = '0;
              phase_d = (hdr_len != '0) ? PhExpBody : PhDone;
            end
            default: begin
              elem_d  = hdr_len;
              phase_d = (hdr_len != '0) ? phase_e'(phase_q + 5'd1)
                                        : phase_e'(phase_q + 5'd2);
            end
          endcase
        end
      end

      if (emit_mod) begin
        cnt_d = cnt_q + CntW'(1);
      end
      push_o.mod_vld = emit_mod;

      if (buffer_end_i) begin
        stat_bad = err_d || (phase_d != PhDone) || (outer_d != '0);
        push_o.stat_vld                = 1'b1;
        push_o.stat_res.status         = stat_bad ? StatusBad : StatusOk;
        push_o.stat_res.modulus_length = ModLenW'(cnt_d);
        push_o.stat_res.exponent       = exp_d;
        // back to reset for the next certificate
        phase_d   = PhCert;
        ver_d     = 1'b0;
        acc_d     = '0;
        lbl_d     = LblTag;
        outer_d   = '0;
        tbs_d     = '0;
        keyinfo_d = '0;
        bits_d    = '0;
        keyseq_d  = '0;
        elem_d    = '0;
        exp_d     = '0;
        cnt_d     = '0;
        err_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhCert;
      ver_q     <= 1'b0;
      acc_q     <= '0;
      lbl_q     <= LblTag;
      outer_q   <= '0;
      tbs_q     <= '0;
      keyinfo_q <= '0;
      bits_q    <= '0;
      keyseq_q  <= '0;
      elem_q    <= '0;
      exp_q     <= '0;
      cnt_q     <= '0;
      err_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ver_q     <= ver_d;
      acc_q     <= acc_d;
      lbl_q     <= lbl_d;
      outer_q   <= outer_d;
      tbs_q     <= tbs_d;
      keyinfo_q <= keyinfo_d;
      bits_q    <= bits_d;
      keyseq_q  <= keyseq_d;
      elem_q    <= elem_d;
      exp_q     <= exp_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
    end
  end

  // last beat always leaves the walker clean
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && buffer_end_i) |=> (phase_q == PhCert) && !err_q)
    else $error("parser not back at certificate header after last beat");

  // an error sticks until the buffer ends
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(accept_i && buffer_end_i)) |=> err_q)
    else $error("error flag dropped before buffer end");

  // length tracker only holds tag, first-length or 1..4 remaining
  a_lbl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lbl_q != 3'd6) && (lbl_q != 3'd7))
    else $error("length byte tracker out of range");

endmodule

[rtl/core/drke_res_fifo.sv]
// ----------------------------------------------------------------------------
// drke_res_fifo
// Small result queue; takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module drke_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  drke_pkg::push_t  push_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output drke_pkg::res_t   head_o
);
  import drke_pkg::*;

  localparam int unsigned CntW = $clog2(ResDepth + 1);

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    n_push;
  logic               pop;
  logic [ResPtrW-1:0] stat_ptr;

  assign pop         = out_valid_o && !out_stall_i;
  assign n_push      = CntW'(push_i.mod_vld) + CntW'(push_i.stat_vld);
  assign stat_ptr    = wr_ptr_q + ResPtrW'(push_i.mod_vld);
  assign rd_ptr_d    = rd_ptr_q + ResPtrW'(pop);
  assign wr_ptr_d    = wr_ptr_q + ResPtrW'(n_push);
  assign count_d     = count_q + n_push - CntW'(pop);
  // room for two results must be there before a beat is taken
  assign full_o      = count_q > CntW'(ResDepth - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.mod_vld) begin
      mem_q[wr_ptr_q] <= push_i.mod_res;
    end
    if (push_i.stat_vld) begin
      mem_q[stat_ptr] <= push_i.stat_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ResDepth))
    else $error("result queue overfilled");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.mod_vld || push_i.stat_vld) |-> !full_o)
    else $error("results pushed while queue full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> count_q <= $past(count_q) + CntW'(1))
    else $error("queue count jumped on a pop cycle");

endmodule

[rtl/core/der_rsa_key_extractor.sv]
// ----------------------------------------------------------------------------
// der_rsa_key_extractor
// Streams a DER certificate and pulls out the RSA modulus and exponent.
//
// Feed the certificate one byte per beat with buffer_end_i set on the final
// byte. Each byte is parsed in the cycle it is accepted, so the block takes
// one byte per clock while in_stall_o is low; a byte raises zero, one or two
// result beats (a modulus byte, the final status, or a modulus byte followed
// by the status). Results sit in a four-entry queue, and in_stall_o rises
// while it holds three or more, so a stalled consumer backs up into the
// input once three or four results are waiting. Modulus bytes leave
// big-endian with one leading zero stripped; the status beat carries the
// error flag, the number of modulus bytes sent and the low 32 bits of the
// exponent. If status reports an error, the modulus bytes sent before it
// must be thrown away. After the final byte the walker is back at reset
// and the next certificate may follow at once.
// ----------------------------------------------------------------------------
module der_rsa_key_extractor #(
  parameter int unsigned ModBytes = drke_pkg::ModBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cert_byte_i,
  input  logic        buffer_end_i,

  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  modulus_byte_o,
  output logic        status_o,
  output logic [9:0]  modulus_length_o,
  output logic [31:0] exponent_o
);
  import drke_pkg::*;

  logic  accept;
  push_t push;
  res_t  head;

  assign accept = in_valid_i && !in_stall_o;

  // TLV walker: all per-byte work sits between its state registers
  drke_parser #(
    .ModBytes (ModBytes)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cert_byte_i  (cert_byte_i),
    .buffer_end_i (buffer_end_i),
    .push_o       (push)
  );

  // result queue decouples the two sides
  drke_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o           = head.kind;
  assign modulus_byte_o   = head.modulus_byte;
  assign status_o         = head.status;
  assign modulus_length_o = head.modulus_length;
  assign exponent_o       = head.exponent;

endmodule

[verif/der_rsa_key_extractor_tb.sv]
// ----------------------------------------------------------------------------
// der_rsa_key_extractor_tb
// Self-checking bench for the DER RSA key extractor. A short table of
// malformed buffers comes first. Then randomly built certificates follow,
// mostly well formed with random content and some corrupted, cut short or
// pure noise. A cycle-free walker of the DER structure predicts every
// modulus byte and every status beat that no literal table row gives. Both
// channels idle at random. The result side is held off for long stretches,
// so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module der_rsa_key_extractor_tb;
  import drke_pkg::*;

  // walker phases: header phases read a TLV header, body phases step
  // over content
  localparam logic [4:0] PhCert       = 5'd0;
  localparam logic [4:0] PhTbs        = 5'd1;
  localparam logic [4:0] PhFirst      = 5'd2;
  localparam logic [4:0] PhVerBody    = 5'd3;
  localparam logic [4:0] PhSerial     = 5'd4;
  localparam logic [4:0] PhSerialBody = 5'd5;
  localparam logic [4:0] PhAlg        = 5'd6;
  localparam logic [4:0] PhAlgBody    = 5'd7;
  localparam logic [4:0] PhIssuer     = 5'd8;
  localparam logic [4:0] PhIssuerBody = 5'd9;
  localparam logic [4:0] PhValid      = 5'd10;
  localparam logic [4:0] PhValidBody  = 5'd11;
  localparam logic [4:0] PhSubj       = 5'd12;
  localparam logic [4:0] PhSubjBody   = 5'd13;
  localparam logic [4:0] PhKeyInfo    = 5'd14;
  localparam logic [4:0] PhAlg2       = 5'd15;
  localparam logic [4:0] PhAlg2Body   = 5'd16;
  localparam logic [4:0] PhBits       = 5'd17;
  localparam logic [4:0] PhPad        = 5'd18;
  localparam logic [4:0] PhKeySeq     = 5'd19;
  localparam logic [4:0] PhMod        = 5'd20;
  localparam logic [4:0] PhModFirst   = 5'd21;
  localparam logic [4:0] PhModRest    = 5'd22;
  localparam logic [4:0] PhExp        = 5'd23;
  localparam logic [4:0] PhExpBody    = 5'd24;
  localparam logic [4:0] PhDone       = 5'd25;

  // length-byte tracking: tag next, or first length byte next
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenFirst = 3'd5;

  localparam int unsigned NDir        = 20;
  localparam int unsigned RandomBytes = 1900;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainLimit  = 5000;
  localparam int unsigned TailCycles  = 16;
  // time limit for the slowest run of ~2500 beats, with a wide margin
  localparam longint      RunLimit    = 64'd12_000_000;

  typedef logic [7:0] octets_t [$];

  // one directed beat; status, length and exponent are only used when
  // literal is set, otherwise the walker supplies the expectation
  typedef struct packed {
    logic [7:0]  octet;
    logic        last;
    logic        literal;
    logic        status;
    logic [9:0]  mod_len;
    logic [31:0] expo;
  } dir_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  cert_byte_i  = 8'h00;
  logic        buffer_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        kind_o;
  logic [7:0]  modulus_byte_o;
  logic        status_o;
  logic [9:0]  modulus_length_o;
  logic [31:0] exponent_o;

  der_rsa_key_extractor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cert_byte_i      (cert_byte_i),
    .buffer_end_i     (buffer_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .modulus_byte_o   (modulus_byte_o),
    .status_o         (status_o),
    .modulus_length_o (modulus_length_o),
    .exponent_o       (exponent_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // DER walker: own copy of the parse state, stepped once per accepted beat
  // ---------------------------------------------------------------------------
  logic [4:0]  w_phase;
  logic [7:0]  w_tag;
  logic [31:0] w_len_acc;
  logic [2:0]  w_len_left;
  logic [32:0] w_outer, w_tbs, w_keyinfo, w_bits, w_keyseq, w_elem;
  logic [31:0] w_exp;
  logic [9:0]  w_modcnt;
  logic        w_err;

  res_t        key_beats_due [$];   // result beats still to come, oldest first

  int unsigned bytes_sent  = 0;
  int unsigned buffers     = 0;
  int unsigned beats_seen  = 0;
  int unsigned mod_beats   = 0;
  int unsigned keys_ok     = 0;
  int unsigned keys_bad    = 0;
  int unsigned holds       = 0;
  int unsigned faults      = 0;
  logic        tx_calm     = 1'b0;

  task automatic walk_reset();
    w_phase    = PhCert;
    w_tag      = '0;
    w_len_acc  = '0;
    w_len_left = LenNone;
    w_outer    = '0;
    w_tbs      = '0;
    w_keyinfo  = '0;
    w_bits     = '0;
    w_keyseq   = '0;
    w_elem     = '0;
    w_exp      = '0;
    w_modcnt   = '0;
    w_err      = 1'b0;
  endtask

  function automatic logic [32:0] cnt_dec(logic [32:0] v);
    return (v != '0) ? v - 33'd1 : '0;
  endfunction

  // skipped element: count its content down, or move two phases on if empty
  task automatic open_skip(input logic [4:0] hdr, input logic [32:0] len);
    w_elem  = len;
    w_phase = (len != '0) ? hdr + 5'd1 : hdr + 5'd2;
  endtask

  // a complete length has arrived: check it against the enclosing room
  task automatic close_header(input logic [32:0] room, input logic bounded);
    logic [32:0] len;
    len        = {1'b0, w_len_acc};
    w_len_left = LenNone;
    if (bounded && len > room) begin
      w_err = 1'b1;
    end else begin
      case (w_phase)
        PhCert: begin
          w_outer = len;
          w_phase = PhTbs;
        end
        PhTbs: begin
          w_tbs   = len;
          w_phase = PhFirst;
        end
        PhFirst: open_skip((w_tag == TagVersion) ? PhFirst : PhSerial, len);
        PhKeyInfo: begin
          w_keyinfo = len;
          w_phase   = PhAlg2;
        end
        PhBits: begin
          w_bits = len;
          if (len == '0) w_err = 1'b1;
          else w_phase = PhPad;
        end
        PhKeySeq: begin
          w_keyseq = len;
          w_phase  = PhMod;
        end
        PhMod: begin
          if (len > 33'(ModBytesDefault) + 33'd1) begin
            w_err = 1'b1;
          end else begin
            w_elem  = len;
            w_phase = (len != '0) ? PhModFirst : PhExp;
          end
        end
        PhExp: begin
          w_elem  = len;
          w_exp   = '0;
          w_phase = (len != '0) ? PhExpBody : PhDone;
        end
        default: open_skip(w_phase, len);
      endcase
    end
  endtask

  // step the walker by one beat; with keep set the beats it raises are queued
  task automatic walk_cert_byte(input logic [7:0] b, input logic last, input logic keep);
    logic [4:0]  ph;
    logic        hdr, bounded, any_tag, emit;
    logic [32:0] enc, elem_before, room;
    logic [7:0]  want;
    logic [6:0]  nlen;
    res_t        beat;
    ph          = w_phase;
    elem_before = w_elem;
    bounded     = 1'b0;
    any_tag     = 1'b0;
    emit        = 1'b0;
    enc         = '0;
    want        = TagSequence;
    case (ph)
      PhCert, PhTbs, PhFirst, PhSerial, PhAlg, PhIssuer, PhValid, PhSubj,
      PhKeyInfo, PhAlg2, PhBits, PhKeySeq, PhMod, PhExp: hdr = 1'b1;
      default: hdr = 1'b0;
    endcase

    // room left in the enclosing element, taken before this beat counts
    if (hdr) begin
      bounded = 1'b1;
      case (ph)
        PhCert:         bounded = 1'b0;
        PhTbs:          enc = w_outer;
        PhAlg2, PhBits: enc = w_keyinfo;
        PhKeySeq:       enc = w_bits;
        PhMod, PhExp:   enc = w_keyseq;
        default:        enc = w_tbs;
      endcase
      case (ph)
        PhCert, PhTbs, PhKeyInfo, PhKeySeq: want = TagSequence;
        PhBits:                             want = TagBitString;
        PhMod, PhExp:                       want = TagInteger;
        default:                            any_tag = 1'b1;
      endcase
    end
    room = enc - {32'd0, bounded};

    w_outer   = cnt_dec(w_outer);
    w_tbs     = cnt_dec(w_tbs);
    w_keyinfo = cnt_dec(w_keyinfo);
    w_bits    = cnt_dec(w_bits);
    w_keyseq  = cnt_dec(w_keyseq);
    w_elem    = cnt_dec(w_elem);

    if (!w_err && ph != PhDone) begin
      if (hdr) begin
        if (bounded && enc == '0) begin
          w_err = 1'b1;
        end else if (w_len_left == LenNone) begin
          w_tag = b;
          if (!any_tag && b != want) w_err = 1'b1;
          else w_len_left = LenFirst;
        end else if (w_len_left == LenFirst) begin
          if (b[7]) begin
            nlen = b[6:0] & LongLenMask;
            if (nlen == '0 || nlen > 7'(MaxLenBytes)) begin
              w_err = 1'b1;
            end else begin
              w_len_acc  = '0;
              w_len_left = nlen[2:0];
            end
          end else begin
            w_len_acc = {24'd0, b};
            close_header(room, bounded);
          end
        end else begin
          w_len_acc  = {w_len_acc[23:0], b};
          w_len_left = w_len_left - 3'd1;
          if (w_len_left == LenNone) close_header(room, bounded);
        end
      end else begin
        case (ph)
          PhPad: begin
            if (b != PadByte) w_err = 1'b1;
            else w_phase = PhKeySeq;
          end
          PhModFirst: begin
            // one leading zero goes, but only from a modulus longer than a byte
            if (elem_before > 33'd1 && b == ZeroByte) begin
              w_phase = (w_elem != '0) ? PhModRest : PhExp;
            end else if (elem_before > 33'(ModBytesDefault)) begin
              w_err = 1'b1;
            end else begin
              emit    = 1'b1;
              w_phase = (w_elem != '0) ? PhModRest : PhExp;
            end
          end
          PhModRest: begin
            emit = 1'b1;
            if (w_elem == '0) w_phase = PhExp;
          end
          PhExpBody: begin
            w_exp = {w_exp[23:0], b};
            if (w_elem == '0) w_phase = PhDone;
          end
          PhVerBody, PhSerialBody, PhAlgBody, PhIssuerBody, PhValidBody,
          PhSubjBody, PhAlg2Body: begin
            if (w_elem == '0) w_phase = ph + 5'd1;
          end
          default: w_err = 1'b1;
        endcase
      end
    end

    if (emit) begin
      beat              = '0;
      beat.kind         = KindModByte;
      beat.modulus_byte = b;
      if (keep) key_beats_due.push_back(beat);
      w_modcnt = w_modcnt + 10'd1;
    end

    if (last) begin
      beat                = '0;
      beat.kind           = KindStatus;
      beat.status         = (w_err || w_phase != PhDone || w_outer != '0) ? StatusBad
                                                                          : StatusOk;
      beat.modulus_length = w_modcnt;
      beat.exponent       = w_exp;
      if (keep) key_beats_due.push_back(beat);
      walk_reset();
    end
  endtask

  // ---------------------------------------------------------------------------
  // certificate builder
  // ---------------------------------------------------------------------------
  function automatic octets_t cat(octets_t a, octets_t b);
    octets_t r;
    r = a;
    foreach (b[i]) r.push_back(b[i]);
    return r;
  endfunction

  function automatic octets_t rand_octets(int unsigned n);
    octets_t r;
    repeat (n) r.push_back(8'($urandom_range(0, 255)));
    return r;
  endfunction

  // skipped fields mostly carry a SEQUENCE tag, now and then anything at all
  function automatic logic [7:0] field_tag();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : TagSequence;
  endfunction

  // TLV around body; short form or long form, sometimes with a spare length byte
  function automatic octets_t der_wrap(logic [7:0] tag, octets_t body);
    octets_t     o;
    int unsigned n, k, i;
    n = body.size();
    o.push_back(tag);
    if (n < 128 && $urandom_range(0, 3) != 0) begin
      o.push_back(8'(n));
    end else begin
      k = (n < 256) ? 1 : (n < 65536) ? 2 : 3;
      if ($urandom_range(0, 3) == 0) k++;
      o.push_back(8'h80 | 8'(k));
      for (i = k; i > 0; i--) o.push_back(8'(n >> (8 * (i - 1))));
    end
    return cat(o, body);
  endfunction

  function automatic octets_t build_cert(int unsigned mod_len, logic lead_zero);
    octets_t     modv, key, bits, ki, tbs, cert;
    int unsigned f;
    modv = rand_octets(mod_len);
    if (lead_zero) modv.push_front(ZeroByte);
    key = cat(der_wrap(TagInteger, modv),
              der_wrap(TagInteger, rand_octets($urandom_range(0, 6))));
    // bytes after the exponent inside the key sequence only count down
    if ($urandom_range(0, 3) == 0) key = cat(key, rand_octets($urandom_range(1, 3)));
    bits = der_wrap(TagSequence, key);
    bits.push_front(PadByte);
    bits = der_wrap(TagBitString, bits);
    ki   = der_wrap(TagSequence,
                    cat(der_wrap(field_tag(), rand_octets($urandom_range(0, 4))), bits));
    if ($urandom_range(0, 1) == 0)
      tbs = der_wrap(TagVersion, rand_octets($urandom_range(0, 3)));
    for (f = 0; f < 5; f++)
      tbs = cat(tbs, der_wrap(field_tag(), rand_octets($urandom_range(0, 6))));
    tbs = cat(tbs, ki);
    if ($urandom_range(0, 2) == 0) tbs = cat(tbs, rand_octets($urandom_range(1, 5)));
    cert = der_wrap(TagSequence,
                    cat(der_wrap(TagSequence, tbs), rand_octets($urandom_range(0, 6))));
    // trailing bytes past the certificate are ignored
    if ($urandom_range(0, 4) == 0) cert = cat(cert, rand_octets($urandom_range(1, 3)));
    return cert;
  endfunction

  // ---------------------------------------------------------------------------
  // byte channel: inputs move on the falling edge, one beat per call
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cert_byte_i  <= b;
    buffer_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random stalls per beat, plus two long hold-offs so the
  // result queue fills and the input backs up while bytes keep coming
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_n;
    int unsigned hold_marks [2];
    logic        calm;
    hold_marks = '{150, 900};
    calm       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds < 2 && beats_seen >= hold_marks[holds]) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        holds++;
      end
      if ($urandom_range(0, 29) == 0) calm = !calm;
      wait_n = calm ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_check
    res_t got, due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind           = kind_o;
      got.modulus_byte   = modulus_byte_o;
      got.status         = status_o;
      got.modulus_length = modulus_length_o;
      got.exponent       = exponent_o;
      beats_seen++;
      if (key_beats_due.size() == 0) begin
        if (faults < 10)
          $display("%0t: unexpected beat kind %0d byte %02h status %0d len %0d exp %08h",
                   $time, got.kind, got.modulus_byte, got.status, got.modulus_length,
                   got.exponent);
        faults++;
      end else begin
        due = key_beats_due.pop_front();
        if (got.kind !== due.kind || got.modulus_byte !== due.modulus_byte ||
            got.status !== due.status || got.modulus_length !== due.modulus_length ||
            got.exponent !== due.exponent) begin
          if (faults < 10) begin
            $display("%0t: mismatch, expected kind %0d byte %02h status %0d len %0d exp %08h",
                     $time, due.kind, due.modulus_byte, due.status, due.modulus_length,
                     due.exponent);
            $display("%0t:           got kind %0d byte %02h status %0d len %0d exp %08h",
                     $time, got.kind, got.modulus_byte, got.status, got.modulus_length,
                     got.exponent);
          end
          faults++;
        end
        if (due.kind == KindModByte) mod_beats++;
        else if (due.status == StatusOk) keys_ok++;
        else keys_bad++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    dir_rows [NDir];
    octets_t     stream;
    res_t        lit;
    int unsigned i, pick, mod_len, k, drained;

    dir_rows = '{
      // wrong outer tag, at both byte extremes
      '{8'h00,       1'b1, 1'b1, StatusBad, 10'd0, 32'd0},
      '{8'hFF,       1'b1, 1'b1, StatusBad, 10'd0, 32'd0},
      // buffer ends right after the outer tag
      '{TagSequence, 1'b1, 1'b1, StatusBad, 10'd0, 32'd0},
      // long form with no length bytes
      '{TagSequence, 1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'h80,       1'b1, 1'b1, StatusBad, 10'd0, 32'd0},
      // long form claiming 127 length bytes
      '{TagSequence, 1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'hFF,       1'b1, 1'b1, StatusBad, 10'd0, 32'd0},
      // four-byte maximum outer length, empty tbs, then a field with no room
      '{TagSequence, 1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'h84,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'hFF,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'hFF,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'hFF,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'hFF,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{TagSequence, 1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'h00,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'h05,       1'b1, 1'b1, StatusBad, 10'd0, 32'd0},
      // five length bytes, then everything up to the flagged byte is ignored
      '{TagSequence, 1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'h85,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{8'hAB,       1'b0, 1'b0, StatusOk,  10'd0, 32'd0},
      '{TagSequence, 1'b1, 1'b0, StatusOk,  10'd0, 32'd0}
    };

    walk_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table; literal rows carry their own status beat
    for (i = 0; i < NDir; i++) begin
      offer_byte(dir_rows[i].octet, dir_rows[i].last);
      walk_cert_byte(dir_rows[i].octet, dir_rows[i].last, !dir_rows[i].literal);
      if (dir_rows[i].literal) begin
        lit                = '0;
        lit.kind           = KindStatus;
        lit.status         = dir_rows[i].status;
        lit.modulus_length = dir_rows[i].mod_len;
        lit.exponent       = dir_rows[i].expo;
        key_beats_due.push_back(lit);
      end
    end

    // random buffers: mostly well formed, some corrupted, cut short or noise
    while (bytes_sent < NDir + RandomBytes) begin
      buffers++;
      pick = $urandom_range(0, 9);
      if (buffers == 2) begin
        // full-size modulus behind a leading zero: length reaches its top
        stream = build_cert(ModBytesDefault, 1'b1);
      end else if (pick == 0) begin
        stream = rand_octets($urandom_range(1, 12));
        if ($urandom_range(0, 1) == 0) stream[0] = TagSequence;
      end else begin
        mod_len = ($urandom_range(0, 29) == 0) ? $urandom_range(ModBytesDefault - 2,
                                                                ModBytesDefault + 2)
                                               : $urandom_range(0, 24);
        stream  = build_cert(mod_len, $urandom_range(0, 2) == 0);
        if (pick == 1) begin
          stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick == 2) begin
          k      = $urandom_range(0, stream.size() - 2);
          stream = stream[0:k];
        end
      end
      foreach (stream[j]) begin
        offer_byte(stream[j], j == stream.size() - 1);
        walk_cert_byte(stream[j], j == stream.size() - 1, 1'b1);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then keep watching for a tail of stray beats
    drained = 0;
    while (key_beats_due.size() != 0 && drained < DrainLimit) begin
      @(posedge clk_i);
      drained++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (key_beats_due.size() != 0) begin
      $display("%0d expected result beats never arrived", key_beats_due.size());
      faults += key_beats_due.size();
    end

    $display("covered %0d bytes in %0d random buffers after %0d table beats",
             bytes_sent, buffers, NDir);
    $display("%0d modulus bytes, %0d keys extracted, %0d buffers rejected, %0d hold-offs",
             mod_beats, keys_ok, keys_bad, holds);
    if (faults == 0) begin
      $display("der_rsa_key_extractor_tb: done, clean");
    end else begin
      $display("der_rsa_key_extractor_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimit);
    $display("der_rsa_key_extractor_tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
rtl/core/drke_pkg.sv
rtl/core/drke_parser.sv
rtl/core/drke_res_fifo.sv
rtl/core/der_rsa_key_extractor.sv
verif/der_rsa_key_extractor_tb.sv
